// ----- rtl/ekct_pkg.sv -----
package ekct_pkg;

   // Default table size
   localparam int SLOTS_DEF = 8;

   // Field widths
   localparam int TIME_W = 32;
   localparam int CHAN_W = 3;
   localparam int SESS_W = 32;
   localparam int WORD_W = 64;
   localparam int KEY_W  = 4 * WORD_W;
   localparam int FUNC_W = 2;
   localparam int SLOT_W = 3;
   localparam int ACT_W  = 2;

   // Stream widths, tdata widths rounded up to whole bytes
   localparam int REQ_DATA_W  = TIME_W + CHAN_W + SESS_W + KEY_W;
   localparam int REQ_TDATA_W = ((REQ_DATA_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = SLOT_W + SESS_W + KEY_W;
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 1 + ACT_W;

   localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd3600000;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   // Result action codes
   localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_UPDATE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd3;

   // Request payload, now_time in the low bits
   typedef struct packed {
      logic [WORD_W-1:0] key_word3;
      logic [WORD_W-1:0] key_word2;
      logic [WORD_W-1:0] key_word1;
      logic [WORD_W-1:0] key_word0;
      logic [SESS_W-1:0] session_id;
      logic [CHAN_W-1:0] channel;
      logic [TIME_W-1:0] now_time;
   } req_fields_type;

   // Response payload
   typedef struct packed {
      logic [WORD_W-1:0] out_word3;
      logic [WORD_W-1:0] out_word2;
      logic [WORD_W-1:0] out_word1;
      logic [WORD_W-1:0] out_word0;
      logic [SESS_W-1:0] found_session;
      logic [SLOT_W-1:0] slot;
   } rsp_fields_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             hit;
   } rsp_user_type;

   // One stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
      logic [SESS_W-1:0] session;
      logic [CHAN_W-1:0] channel;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic load;    // capture request, restart scan
      logic scan;    // issue one table read, advance address
      logic commit;  // write back, load response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_scan;  // incoming op must walk the filled slots
      logic scan_last;  // read being issued is the last filled slot
      logic rsp_busy;   // response register holds an untaken result
   } sts_type;

endpackage

// ----- rtl/expiring_key_cache_table_top.sv -----
// Expiring key cache: a table of SLOTS entries (channel, session id, time stamp,
// 256-bit key). Ops on req_tuser: insert (update a matching channel/session,
// else append, else replace the oldest stamp, lowest slot on ties), lookup
// (session zero: newest unexpired stamp above zero on the channel; otherwise
// the first unexpired exact match) and clear. An entry is unexpired while
// (now_time - stamp) mod 2^32 < lifetime_ticks, set through the csr channel.
// One op is in flight at a time. Insert and lookup walk the filled slots
// through the single read port of the table, one slot per cycle, then pass
// through a drain state and a commit state before the next accept; clear,
// the unused code and ops on an empty table go straight to commit. The
// result sits in an output register, so a new request is taken while
// a result waits; only the write-back waits for the output to drain. No
// clearing pass after reset: the fill count marks which slots hold data.
module expiring_key_cache_table_top
   import ekct_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [FUNC_W-1:0]      req_tuser,   // func
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // now_time, channel, session_id,
                                               // key_word0..key_word3, zero pad
   // lifetime register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [TIME_W-1:0]      csr_data,    // lifetime_ticks
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // hit, action
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // slot, found_session,
                                               // out_word0..out_word3, zero pad
);

   cmd_type cmd;
   sts_type sts;

   // register writes are always taken
   assign csr_ready = 1'b1;

   ekct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ekct_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   // one op in flight: no second transfer right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous op in flight");

   // write-back never overwrites an untaken result
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !sts.rsp_busy)
      else $error("commit with result register still occupied");

   // a result only appears after a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.commit))
      else $error("result valid without commit");

   // scanning and accepting are exclusive
   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (!req_tready && !cmd.commit))
      else $error("scan overlaps accept or commit");

endmodule

// ----- rtl/ekct_ctrl.sv -----
module ekct_ctrl
   import ekct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.need_scan ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last read data is evaluated this cycle
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ekct_dp.sv -----
module ekct_dp
   import ekct_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [FUNC_W-1:0]      req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [TIME_W-1:0]      csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILL_W = $clog2(SLOTS + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS);

   entry_type mem [SLOTS];

   logic [FUNC_W-1:0] op_ff, op_in;
   req_fields_type    req_ff, req_in;
   logic [TIME_W-1:0] lifetime_ff, lifetime_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   entry_type         rd_ent_ff;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [SESS_W-1:0] cap_sess_ff, cap_sess_in;
   logic [KEY_W-1:0]  cap_key_ff, cap_key_in;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_user_type      rsp_user_ff, rsp_user_in;
   rsp_fields_type    rsp_data_ff, rsp_data_in;

   req_fields_type    req_fields;
   logic              is_insert, is_lookup;
   logic              ch_eq, ss_eq, unexpired;
   logic [TIME_W-1:0] age;
   logic              take_hit, take_min;
   logic              has_room;
   logic [IDX_W-1:0]  target;
   logic [ACT_W-1:0]  act;
   logic              do_write;

   assign req_fields = req_fields_type'(req_tdata[REQ_DATA_W-1:0]);
   assign is_insert  = (op_ff == FUNC_INSERT);
   assign is_lookup  = (op_ff == FUNC_LOOKUP);
   assign has_room   = (fill_ff != FILL_FULL);

   // status
   assign sts.need_scan = ((req_tuser == FUNC_INSERT) || (req_tuser == FUNC_LOOKUP))
                          && (fill_ff != '0);
   assign sts.scan_last = ((FILL_W'(addr_ff) + FILL_W'(1)) == fill_ff);
   assign sts.rsp_busy  = rsp_vld_ff && !rsp_tready;

   // per-slot evaluation of the registered read
   assign ch_eq     = (rd_ent_ff.channel == req_ff.channel);
   assign ss_eq     = (rd_ent_ff.session == req_ff.session_id);
   assign age       = req_ff.now_time - rd_ent_ff.stamp;
   assign unexpired = (age < lifetime_ff);

   always_comb begin
      take_hit = 1'b0;
      if (rd_vld_ff) begin
         if (is_insert) begin
            take_hit = ch_eq && ss_eq && !found_ff;
         end else if (is_lookup) begin
            if (req_ff.session_id == '0) begin
               take_hit = ch_eq && unexpired && (rd_ent_ff.stamp > best_ff);
            end else begin
               take_hit = ch_eq && ss_eq && unexpired && !found_ff;
            end
         end
      end
   end

   assign take_min = rd_vld_ff && is_insert
                     && ((rd_idx_ff == '0) || (rd_ent_ff.stamp < best_ff));

   // insert target selection
   always_comb begin
      if (found_ff) begin
         target = hit_idx_ff;
         act    = ACT_UPDATE;
      end else if (has_room) begin
         target = IDX_W'(fill_ff);
         act    = ACT_APPEND;
      end else begin
         target = min_idx_ff;
         act    = ACT_REPLACE;
      end
   end

   assign do_write = cmd.commit && is_insert;

   always_comb begin
      op_in       = cmd.load ? req_tuser : op_ff;
      req_in      = cmd.load ? req_fields : req_ff;
      lifetime_in = (csr_valid && csr_ready) ? csr_data : lifetime_ff;
      addr_in     = cmd.load ? '0 : (cmd.scan ? addr_ff + IDX_W'(1) : addr_ff);

      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      best_in     = best_ff;
      min_idx_in  = min_idx_ff;
      cap_sess_in = cap_sess_ff;
      cap_key_in  = cap_key_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         best_in  = '0;
      end else begin
         if (take_hit) begin
            found_in   = 1'b1;
            hit_idx_in = rd_idx_ff;
            if (is_lookup) begin
               best_in     = rd_ent_ff.stamp;
               cap_sess_in = rd_ent_ff.session;
               cap_key_in  = rd_ent_ff.key;
            end
         end
         if (take_min) begin
            best_in    = rd_ent_ff.stamp;
            min_idx_in = rd_idx_ff;
         end
      end

      fill_in = fill_ff;
      if (cmd.commit && (op_ff == FUNC_CLEAR)) begin
         fill_in = '0;
      end else if (do_write && !found_ff && has_room) begin
         fill_in = fill_ff + FILL_W'(1);
      end

      rsp_vld_in  = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_user_in = '0;
         rsp_data_in = '0;
         if (is_insert) begin
            rsp_user_in.action = act;
            rsp_data_in.slot   = SLOT_W'(target);
         end else if (is_lookup && found_ff) begin
            rsp_user_in.hit           = 1'b1;
            rsp_data_in.slot          = SLOT_W'(hit_idx_ff);
            rsp_data_in.found_session = cap_sess_ff;
            rsp_data_in.out_word0     = cap_key_ff[0*WORD_W +: WORD_W];
            rsp_data_in.out_word1     = cap_key_ff[1*WORD_W +: WORD_W];
            rsp_data_in.out_word2     = cap_key_ff[2*WORD_W +: WORD_W];
            rsp_data_in.out_word3     = cap_key_ff[3*WORD_W +: WORD_W];
         end
      end
   end

   // table storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[target] <= '{key:     {req_ff.key_word3, req_ff.key_word2,
                                    req_ff.key_word1, req_ff.key_word0},
                          stamp:   req_ff.now_time,
                          session: req_ff.session_id,
                          channel: req_ff.channel};
      end
      if (cmd.scan) begin
         rd_ent_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
         fill_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         op_ff       <= FUNC_INSERT;
         found_ff    <= 1'b0;
      end else begin
         lifetime_ff <= lifetime_in;
         fill_ff     <= fill_in;
         rd_vld_ff   <= cmd.scan;
         rsp_vld_ff  <= rsp_vld_in;
         op_ff       <= op_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= addr_ff;
      hit_idx_ff  <= hit_idx_in;
      best_ff     <= best_in;
      min_idx_ff  <= min_idx_in;
      cap_sess_ff <= cap_sess_in;
      cap_key_ff  <= cap_key_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);

endmodule
